// ===== hdl/atu64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu64_pkg
// Types and constants shared by the ASCII to unsigned 64-bit parser.
// ----------------------------------------------------------------------------
package atu64_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 5;
  localparam int unsigned DigitW = 4;

  // digit limits, leading zeros included
  localparam logic [CountW-1:0] LIM_DEC = 5'd20;
  localparam logic [CountW-1:0] LIM_OCT = 5'd23;
  localparam logic [CountW-1:0] LIM_HEX = 5'd16;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [CharW-1:0] CH_NINE  = 8'h39; // '9'
  localparam logic [CharW-1:0] CH_LC_A  = 8'h61; // 'a'
  localparam logic [CharW-1:0] CH_LC_F  = 8'h66; // 'f'
  localparam logic [CharW-1:0] CH_UC_A  = 8'h41; // 'A'
  localparam logic [CharW-1:0] CH_UC_F  = 8'h46; // 'F'
  localparam logic [CharW-1:0] CH_LC_X  = 8'h78; // 'x'

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ZERO  = 2'd1,
    PH_ZEROX = 2'd2,
    PH_RUN   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    AB_DEC = 2'd0,
    AB_OCT = 2'd1,
    AB_HEX = 2'd2
  } base_t;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] cnt;
    phase_t            phase;
    base_t             base;
    logic              err;
  } str_state_t;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] cnt;
  } dig_res_t;

  localparam str_state_t STR_RESET = '{
    acc:   '0,
    cnt:   '0,
    phase: PH_START,
    base:  AB_DEC,
    err:   1'b0
  };

endpackage

// ===== hdl/ascii_to_u64_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_u64_parser_top
// Streaming ASCII to unsigned 64-bit integer parser: one character per
// transfer, one result (value and error flag) per NUL-terminated string.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                               Direction  Transfer when
//  in       in_valid/in_ready, in_char_code     input      in_valid & in_ready
//  out      out_valid/out_ready, out_value,     output     out_valid & out_ready
//           out_error
//  cfg      cfg_wr_en, cfg_wr_data              input      cfg_wr_en
//
// One character per cycle sustained while no NUL waits on a full output
// register. A character is held in the input register and parsed there by
// the step logic; a NUL that advances loads its result into the output
// register, which raises out_valid. Only a NUL waits for the output register
// to be free; other characters advance regardless of out_ready. Synchronous
// active-low reset clears the string state, both valid flags and the base mode.
// ----------------------------------------------------------------------------
module ascii_to_u64_parser_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [atu64_pkg::CharW-1:0]       in_char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [atu64_pkg::ValueW-1:0]      out_value,
  output logic                              out_error,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_wr_data
);

  // configuration
  atu64_pkg::mode_t             mode_r;

  // input register
  logic                         in_vld_r;
  logic [atu64_pkg::CharW-1:0]  in_char_r;

  // string state
  atu64_pkg::str_state_t        st_r;
  atu64_pkg::str_state_t        st_nxt;

  // result register
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  logic [atu64_pkg::ValueW-1:0] out_value_r;
  logic                         out_error_r;

  logic                         is_nul;
  logic [atu64_pkg::ValueW-1:0] res_value;
  logic                         res_error;
  logic                         advance;

  atu64_step u_step (
    .cur       (st_r),
    .mode      (mode_r),
    .char_code (in_char_r),
    .nxt       (st_nxt),
    .is_nul    (is_nul),
    .res_value (res_value),
    .res_error (res_error)
  );

  // advance the held character unless it is a NUL facing a full output
  assign advance  = in_vld_r && (!is_nul || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && is_nul) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= atu64_pkg::MODE_AUTO;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= atu64_pkg::STR_RESET;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= atu64_pkg::mode_t'(cfg_wr_data);
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
    end
    if (advance && is_nul) begin
      out_value_r <= res_value;
      out_error_r <= res_error;
    end
  end

  assign out_valid = out_vld_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule

// ===== hdl/atu64_digit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu64_digit
// Decodes one digit character and folds it into the accumulator, with digit
// count limit, digit range and 64-bit overflow checks.
// ----------------------------------------------------------------------------
module atu64_digit (
  input  atu64_pkg::base_t                    base,
  input  logic [atu64_pkg::ValueW-1:0]        acc,
  input  logic [atu64_pkg::CountW-1:0]        cnt,
  input  logic [atu64_pkg::CharW-1:0]         char_code,
  output atu64_pkg::dig_res_t                 res
);

  localparam int unsigned WideW = atu64_pkg::ValueW + 4;

  logic [atu64_pkg::DigitW-1:0] dval;
  logic                         dvalid;
  logic [atu64_pkg::CharW-1:0]  doff;
  logic [atu64_pkg::CountW-1:0] limit;
  logic                         in_range;
  logic [WideW-1:0]             wide_acc;
  logic [WideW-1:0]             prod;
  logic [WideW-1:0]             sum;

  always_comb begin
    dvalid = 1'b1;
    doff   = '0;
    if (char_code >= atu64_pkg::CH_ZERO && char_code <= atu64_pkg::CH_NINE) begin
      doff = char_code - atu64_pkg::CH_ZERO;
    end else if (char_code >= atu64_pkg::CH_LC_A && char_code <= atu64_pkg::CH_LC_F) begin
      doff = char_code - atu64_pkg::CH_LC_A + 8'd10;
    end else if (char_code >= atu64_pkg::CH_UC_A && char_code <= atu64_pkg::CH_UC_F) begin
      doff = char_code - atu64_pkg::CH_UC_A + 8'd10;
    end else begin
      dvalid = 1'b0;
    end
    dval = doff[atu64_pkg::DigitW-1:0];
  end

  assign wide_acc = {4'b0, acc};

  // multiply by the radix as shift-add
  always_comb begin
    case (base)
      atu64_pkg::AB_HEX: begin
        limit    = atu64_pkg::LIM_HEX;
        in_range = dvalid;
        prod     = wide_acc << 4;
      end
      atu64_pkg::AB_OCT: begin
        limit    = atu64_pkg::LIM_OCT;
        in_range = dvalid && (dval < 4'd8);
        prod     = wide_acc << 3;
      end
      default: begin
        limit    = atu64_pkg::LIM_DEC;
        in_range = dvalid && (dval < 4'd10);
        prod     = (wide_acc << 3) + (wide_acc << 1);
      end
    endcase
  end

  assign sum = prod + {{(WideW-atu64_pkg::DigitW){1'b0}}, dval};

  always_comb begin
    res.ok  = (cnt < limit) && in_range && (sum[WideW-1:atu64_pkg::ValueW] == 4'd0);
    res.acc = sum[atu64_pkg::ValueW-1:0];
    res.cnt = cnt + 5'd1;
  end

endmodule

// ===== hdl/atu64_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atu64_step
// Next-state logic of the parser: prefix detection, base selection, digit
// accumulation and the result formed on the terminating NUL.
// ----------------------------------------------------------------------------
module atu64_step (
  input  atu64_pkg::str_state_t            cur,
  input  atu64_pkg::mode_t                 mode,
  input  logic [atu64_pkg::CharW-1:0]      char_code,
  output atu64_pkg::str_state_t            nxt,
  output logic                             is_nul,
  output logic [atu64_pkg::ValueW-1:0]     res_value,
  output logic                             res_error
);

  atu64_pkg::base_t                dig_base;
  logic [atu64_pkg::ValueW-1:0]    dig_acc;
  logic [atu64_pkg::CountW-1:0]    dig_cnt;
  logic                            use_dig;
  atu64_pkg::dig_res_t             dig;

  atu64_digit u_digit (
    .base      (dig_base),
    .acc       (dig_acc),
    .cnt       (dig_cnt),
    .char_code (char_code),
    .res       (dig)
  );

  assign is_nul = (char_code == atu64_pkg::CH_NUL);

  always_comb begin
    res_error = cur.err || (cur.phase == atu64_pkg::PH_START) ||
                (cur.phase == atu64_pkg::PH_ZEROX);
    if (res_error || cur.phase == atu64_pkg::PH_ZERO) begin
      res_value = '0;
    end else begin
      res_value = cur.acc;
    end
  end

  always_comb begin
    nxt      = cur;
    dig_base = cur.base;
    dig_acc  = cur.acc;
    dig_cnt  = cur.cnt;
    use_dig  = 1'b0;

    case (cur.phase)
      atu64_pkg::PH_START: begin
        if (mode == atu64_pkg::MODE_DEC) begin
          dig_base = atu64_pkg::AB_DEC;
          use_dig  = 1'b1;
        end else if (char_code == atu64_pkg::CH_ZERO) begin
          nxt.phase = atu64_pkg::PH_ZERO;
        end else if (mode == atu64_pkg::MODE_OCT) begin
          dig_base = atu64_pkg::AB_OCT;
          use_dig  = 1'b1;
        end else if (mode == atu64_pkg::MODE_HEX) begin
          dig_base = atu64_pkg::AB_HEX;
          use_dig  = 1'b1;
        end else begin
          dig_base = atu64_pkg::AB_DEC;
          use_dig  = 1'b1;
        end
      end
      atu64_pkg::PH_ZERO: begin
        if ((mode == atu64_pkg::MODE_AUTO || mode == atu64_pkg::MODE_HEX) &&
            char_code == atu64_pkg::CH_LC_X) begin
          nxt.base  = atu64_pkg::AB_HEX;
          nxt.phase = atu64_pkg::PH_ZEROX;
        end else if (mode == atu64_pkg::MODE_AUTO || mode == atu64_pkg::MODE_OCT) begin
          dig_base = atu64_pkg::AB_OCT;
          use_dig  = 1'b1;
        end else begin
          // leading zero counts as a digit of the whole string
          dig_base = (mode == atu64_pkg::MODE_HEX) ? atu64_pkg::AB_HEX : atu64_pkg::AB_DEC;
          dig_acc  = '0;
          dig_cnt  = 5'd1;
          nxt.acc  = '0;
          nxt.cnt  = 5'd1;
          use_dig  = 1'b1;
        end
      end
      atu64_pkg::PH_ZEROX: begin
        dig_base = atu64_pkg::AB_HEX;
        use_dig  = 1'b1;
      end
      default: begin
        use_dig = 1'b1;
      end
    endcase

    if (use_dig) begin
      nxt.base  = dig_base;
      nxt.phase = atu64_pkg::PH_RUN;
      if (dig.ok) begin
        nxt.acc = dig.acc;
        nxt.cnt = dig.cnt;
      end else begin
        nxt.err = 1'b1;
      end
    end

    // hold everything once an error is seen; NUL restarts the string
    if (cur.err) begin
      nxt = cur;
    end
    if (is_nul) begin
      nxt = atu64_pkg::STR_RESET;
    end
  end

endmodule

// ===== sim/ascii_to_u64_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_u64_parser_top_tb
// Self-checking bench for the streaming ASCII to unsigned 64-bit parser.
// Characters are streamed in with random bursts and gaps. The output side
// stalls on its own pattern. A scoreboard tracks the string state, predicts
// the value and error flag for each NUL, and compares them with every result
// transfer. Short directed strings come first. Random phases follow, each
// under its own base mode.
// ----------------------------------------------------------------------------
module ascii_to_u64_parser_top_tb;
  import atu64_pkg::*;

  localparam int unsigned RANDOM_CHARS = 570;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_NS     = 2_000_000;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              error;
  } parse_result_t;

  // Scoreboard: a running copy of the string state. Each NUL pushes the
  // value and error flag that the block should return for that string.
  class u64_parse_scoreboard;
    mode_t             mode = MODE_AUTO;
    logic [ValueW-1:0] acc = '0;
    int unsigned       ndig = 0;
    phase_t            phase = PH_START;
    base_t             base = AB_DEC;
    bit                bad = 1'b0;
    parse_result_t     expected_q[$];
    int unsigned       mismatches = 0;
    int unsigned       strings_done = 0;
    int unsigned       strings_bad = 0;

    function int unsigned digit_of(logic [CharW-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (c >= CH_LC_A && c <= CH_LC_F) return c - CH_LC_A + 10;
      if (c >= CH_UC_A && c <= CH_UC_F) return c - CH_UC_A + 10;
      return 255;
    endfunction

    function void add_digit(logic [CharW-1:0] c);
      logic [ValueW-1:0] radix, d;
      int unsigned       limit;
      case (base)
        AB_HEX: begin radix = 16; limit = LIM_HEX; end
        AB_OCT: begin radix = 8;  limit = LIM_OCT; end
        default: begin radix = 10; limit = LIM_DEC; end
      endcase
      d = digit_of(c);
      // too many digits, a digit outside the radix, or a carry past 64 bits
      if (ndig >= limit || d >= radix || acc > ({ValueW{1'b1}} - d) / radix) begin
        bad = 1'b1;
      end else begin
        acc = acc * radix + d;
        ndig++;
      end
    endfunction

    function void start_digits(base_t b, logic [CharW-1:0] c);
      base = b;
      phase = PH_RUN;
      add_digit(c);
    endfunction

    function void note_char(logic [CharW-1:0] c);
      parse_result_t r;
      if (c == CH_NUL) begin
        r.error = bad || phase == PH_START || phase == PH_ZEROX;
        r.value = (r.error || phase == PH_ZERO) ? '0 : acc;
        expected_q.push_back(r);
        acc = '0;
        ndig = 0;
        phase = PH_START;
        base = AB_DEC;
        bad = 1'b0;
        return;
      end
      // once a string has failed, drop everything up to its NUL
      if (bad) return;
      case (phase)
        PH_START: begin
          if (mode == MODE_DEC) start_digits(AB_DEC, c);
          else if (c == CH_ZERO) phase = PH_ZERO;
          else if (mode == MODE_OCT) start_digits(AB_OCT, c);
          else if (mode == MODE_HEX) start_digits(AB_HEX, c);
          else start_digits(AB_DEC, c);
        end
        PH_ZERO: begin
          if ((mode == MODE_AUTO || mode == MODE_HEX) && c == CH_LC_X) begin
            base = AB_HEX;
            phase = PH_ZEROX;
          end else if (mode == MODE_AUTO || mode == MODE_OCT) begin
            start_digits(AB_OCT, c);
          end else begin
            // the leading zero becomes a counted digit of the whole string
            acc = '0;
            ndig = 1;
            start_digits((mode == MODE_HEX) ? AB_HEX : AB_DEC, c);
          end
        end
        PH_ZEROX: start_digits(AB_HEX, c);
        default: add_digit(c);
      endcase
    endfunction

    function void flag(string what, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [ValueW-1:0] v, logic e);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        flag("result with no string pending", '0, v);
        return;
      end
      want = expected_q.pop_front();
      strings_done++;
      if (want.error) strings_bad++;
      if (v !== want.value) flag("value", want.value, v);
      if (e !== want.error) flag("error flag", want.error, e);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CharW-1:0]    in_char_code;
  logic                out_valid;
  logic                out_ready;
  logic [ValueW-1:0]   out_value;
  logic                out_error;
  logic                cfg_wr_en;
  logic [1:0]          cfg_wr_data;

  u64_parse_scoreboard sb;
  bit                  hold_off_req = 1'b0;
  bit                  gaps_on = 1'b1;
  int unsigned         burst_left = 0;
  int unsigned         chars_sent = 0;
  int unsigned         phase_no = 0;

  ascii_to_u64_parser_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_error    (out_error),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time; far beyond the slowest correct run.
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d strings still pending", sb.pending());
    $display("ascii_to_u64_parser_top: mismatch");
    $finish;
  end

  // Sample both channels at the edge: note every character transfer, then
  // check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_char_code);
      if (out_valid && out_ready) sb.check_result(out_value, out_error);
    end
  end

  // Receiver: stall in phases of random style and length (always ready,
  // coin toss, mostly stalled, mostly ready). On request, hold off for a
  // long counted stretch so the output register fills and the input stalls.
  initial begin : receiver
    int unsigned style, left;
    style = 0;
    left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        left = 0;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(5, 40);
        end
        left--;
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one character and hold it until its transfer. Between bursts of
  // random length, drop valid for a random gap when gaps are enabled.
  task automatic send_char(input logic [CharW-1:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // Stop offering, let the monitor note the last transfer, wait for every
  // predicted result, then let the block finish any character it still holds.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mode = m;
  endtask

  // Build one string for mode m: mostly well-formed numbers in a radix the
  // mode allows, plus extremes, bare prefixes, corrupted digits and noise.
  function automatic string make_text(mode_t m);
    string             s;
    logic [ValueW-1:0] v;
    int unsigned       kind, radix, pos, n, i;
    kind = $urandom_range(0, 19);
    case (m)
      MODE_DEC: radix = 10;
      MODE_OCT: radix = 8;
      MODE_HEX: radix = 16;
      default: begin
        case ($urandom_range(0, 2))
          0: radix = 10;
          1: radix = 8;
          default: radix = 16;
        endcase
      end
    endcase
    v = {$urandom, $urandom} >> $urandom_range(0, 63);
    // largest value, so the next digit or extra zero tests the limits
    if (kind == 12 || kind == 13) v = '1;
    case (radix)
      8: s = $sformatf("%0o", v);
      16: s = $sformatf("%0h", v);
      default: s = $sformatf("%0d", v);
    endcase
    if (radix == 16) begin
      for (i = 0; i < s.len(); i++) begin
        if (s[i] >= CH_LC_A && $urandom_range(0, 1) == 1) s[i] = byte'(s[i] - 8'h20);
      end
    end
    if (kind == 13) begin
      s = {s, "7"};
    end else if (kind == 12 || $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 2)) s = {"0", s};
    end
    if (radix == 16 && (m == MODE_AUTO || $urandom_range(0, 1) == 1)) s = {"0x", s};
    if (radix == 8 && (m == MODE_AUTO || $urandom_range(0, 1) == 1)) s = {"0", s};
    case (kind)
      14: begin
        case ($urandom_range(0, 3))
          0: s = "";
          1: s = "0";
          2: s = "0x";
          default: s = "0X";
        endcase
      end
      15, 16, 17: begin
        pos = $urandom_range(0, s.len() - 1);
        s[pos] = byte'($urandom_range(1, 255));
      end
      18, 19: begin
        s = "";
        n = $urandom_range(1, 6);
        repeat (n) s = {s, "?"};
        for (i = 0; i < n; i++) s[i] = byte'($urandom_range(1, 255));
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    mode_t m;
    sb = new;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= MODE_AUTO;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty string, lone zero, bare prefix, octal and hex by
    // prefix, mixed-case hex, characters ignored after an error, top code.
    send_text("");
    send_text("0");
    send_text("0x");
    send_text("017");
    send_text("0xfF");
    send_text("1g");
    send_text("\377");
    // hex without prefix keeps the leading zero as a digit
    write_mode(MODE_HEX);
    send_text("0f");
    write_mode(MODE_OCT);
    send_text("08");
    // leading zero under auto, then the rest of the string under decimal
    write_mode(MODE_AUTO);
    send_char(CH_ZERO);
    write_mode(MODE_DEC);
    send_text("5");

    // Random phases, one base mode each; the first four visit every mode.
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      case (phase_no)
        0: m = MODE_HEX;
        1: m = MODE_AUTO;
        2: m = MODE_OCT;
        3: m = MODE_DEC;
        default: m = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      gaps_on = (phase_no % 3) != 1;
      if (phase_no == 2) hold_off_req = 1'b1;
      repeat (10) begin
        if (chars_sent < RANDOM_CHARS) send_text(make_text(m));
      end
      phase_no++;
    end

    wait_drained();
    $display("Checked %0d strings over %0d random phases and all four base modes; %0d errored.",
             sb.strings_done, phase_no, sb.strings_bad);
    $display("Run included a %0d-cycle output hold-off and a full drain before each mode write.",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ascii_to_u64_parser_top: match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("ascii_to_u64_parser_top: mismatch");
    end
    $finish;
  end

endmodule
